### rtl/core/nearest_palette_color_index_defines.svh
// Assertion macros shared by the nearest palette color index RTL.
`ifndef NEAREST_PALETTE_COLOR_INDEX_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_INDEX_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NPCI_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("npci: implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NPCI_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("npci: next-cycle check failed");

`else

`define NPCI_ASSERT_IMPLY(name, clk, rst, pre, post)
`define NPCI_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

### rtl/core/npci_pkg.sv
// Types, constants and palette helper functions for the nearest palette color index block.
`default_nettype none

package npci_pkg;

   localparam int CHAN_W      = 8;
   localparam int IDX_W       = 8;
   localparam int SUM_W       = 10;
   localparam int SCORE_W     = 21;
   localparam int CHAN_COUNT  = 3;
   localparam int GRAY_COUNT  = 24;
   localparam int FIRST_ENTRY = 16;
   localparam int GRAY_FIRST  = 232;
   localparam int GRAY_BASE   = 8;
   localparam int GRAY_STEP   = 10;
   localparam int CUBE_SIDE   = 6;
   localparam int CUBE_ROW    = 36;

   // Cube level codes.
   localparam logic [2:0] LVL_0 = 3'd0;
   localparam logic [2:0] LVL_1 = 3'd1;
   localparam logic [2:0] LVL_2 = 3'd2;
   localparam logic [2:0] LVL_3 = 3'd3;
   localparam logic [2:0] LVL_4 = 3'd4;
   localparam logic [2:0] LVL_5 = 3'd5;

   typedef logic [2:0] level_sel_type;
   typedef logic signed [SCORE_W-1:0] score_type;

   // A score is the squared distance minus the pixel's own sum of squares,
   // so all candidates compare without ever forming the pixel's squares.
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
      score_type        best_score;
      logic [IDX_W-1:0] best_idx;
   } link_type;

   function automatic logic [CHAN_W-1:0] level_value(input level_sel_type sel);
      logic [CHAN_W-1:0] v;
      unique case (sel)
         LVL_0:   v = 8'h00;
         LVL_1:   v = 8'h5F;
         LVL_2:   v = 8'h87;
         LVL_3:   v = 8'hAF;
         LVL_4:   v = 8'hD7;
         LVL_5:   v = 8'hFF;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] level_square(input level_sel_type sel);
      logic [16:0] v;
      unique case (sel)
         LVL_0:   v = 17'd0;
         LVL_1:   v = 17'd9025;
         LVL_2:   v = 17'd18225;
         LVL_3:   v = 17'd30625;
         LVL_4:   v = 17'd46225;
         LVL_5:   v = 17'd65025;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // Cut points lie at the midpoints between levels; a value exactly on a
   // midpoint goes to the lower level, which keeps the lower palette index.
   function automatic level_sel_type nearest_level(input logic [CHAN_W-1:0] c);
      level_sel_type s;
      if (c <= 8'd47)       s = LVL_0;
      else if (c <= 8'd115) s = LVL_1;
      else if (c <= 8'd155) s = LVL_2;
      else if (c <= 8'd195) s = LVL_3;
      else if (c <= 8'd235) s = LVL_4;
      else                  s = LVL_5;
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] cube_index(input level_sel_type r,
                                                   input level_sel_type g,
                                                   input level_sel_type b);
      int unsigned k;
      k = FIRST_ENTRY + CUBE_ROW * int'(r) + CUBE_SIDE * int'(g) + int'(b);
      return IDX_W'(k);
   endfunction

endpackage

`default_nettype wire

### rtl/core/npci_front.sv
// Front end: best cube entry per channel and its score, which seeds the gray chain.
`default_nettype none
`include "nearest_palette_color_index_defines.svh"

module npci_front import npci_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat,
   input  wire logic [CHAN_W-1:0] red,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] blue,
   output link_type               seed
);

   logic              valid_a_ff;
   logic [CHAN_W-1:0] px_ff [CHAN_COUNT];
   level_sel_type     sel_ff [CHAN_COUNT];
   logic [SUM_W-1:0]  sum_a_ff;
   logic [IDX_W-1:0]  idx_a_ff;

   logic              valid_b_ff;
   score_type         term_ff [CHAN_COUNT];
   score_type         term_in [CHAN_COUNT];
   logic [SUM_W-1:0]  sum_b_ff;
   logic [IDX_W-1:0]  idx_b_ff;

   link_type          seed_ff;
   link_type          seed_in;

   // Stage A: pixel capture and nearest level per channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= beat;
      end
      px_ff[0]  <= red;
      px_ff[1]  <= green;
      px_ff[2]  <= blue;
      sel_ff[0] <= nearest_level(red);
      sel_ff[1] <= nearest_level(green);
      sel_ff[2] <= nearest_level(blue);
      sum_a_ff  <= SUM_W'({2'b00, red}) + SUM_W'({2'b00, green}) + SUM_W'({2'b00, blue});
      idx_a_ff  <= cube_index(nearest_level(red), nearest_level(green), nearest_level(blue));
   end

   // Stage B: per channel, level^2 - 2*level*c.
   always_comb begin
      for (int ch = 0; ch < CHAN_COUNT; ch++) begin
         term_in[ch] = score_type'(level_square(sel_ff[ch]))
                     - score_type'({level_value(sel_ff[ch]), 1'b0}) * score_type'(px_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      for (int ch = 0; ch < CHAN_COUNT; ch++) begin
         term_ff[ch] <= term_in[ch];
      end
      sum_b_ff <= sum_a_ff;
      idx_b_ff <= idx_a_ff;
   end

   // Stage C: cube score is the sum of the channel terms.
   always_comb begin
      seed_in.valid      = valid_b_ff;
      seed_in.sum        = sum_b_ff;
      seed_in.best_score = term_ff[0] + term_ff[1] + term_ff[2];
      seed_in.best_idx   = idx_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff.valid <= 1'b0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign seed = seed_ff;

   `NPCI_ASSERT_IMPLY(a_seed_in_cube, clock, reset, seed_ff.valid, (seed_ff.best_idx >= IDX_W'(FIRST_ENTRY)) && (seed_ff.best_idx < IDX_W'(GRAY_FIRST)))
   `NPCI_ASSERT_NEXT(a_seed_follows_beat, clock, reset, valid_b_ff, seed_ff.valid)

endmodule

`default_nettype wire

### rtl/core/npci_cell.sv
// One gray-ramp cell: tests its gray entry against the running best and passes it on.
`default_nettype none
`include "nearest_palette_color_index_defines.svh"

module npci_cell import npci_pkg::*; #(
   parameter int unsigned GRAY_K = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  link_type  up_link,
   output link_type  down_link
);

   localparam int unsigned      GRAY_V = GRAY_BASE + GRAY_STEP * GRAY_K;
   localparam score_type        OFFSET = score_type'(3 * GRAY_V * GRAY_V);
   localparam score_type        SLOPE  = score_type'(2 * GRAY_V);
   localparam logic [IDX_W-1:0] ENTRY  = IDX_W'(GRAY_FIRST + GRAY_K);

   score_type gray_score;
   link_type  link_ff;
   link_type  link_in;

   // For a gray v the score is 3v^2 - 2v*(r+g+b).
   assign gray_score = OFFSET - SLOPE * score_type'(up_link.sum);

   // Only a strictly better score replaces the best, so lower indices win ties.
   always_comb begin
      link_in = up_link;
      if (gray_score < up_link.best_score) begin
         link_in.best_score = gray_score;
         link_in.best_idx   = ENTRY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff <= link_in;
      end
   end

   assign down_link = link_ff;

   `NPCI_ASSERT_NEXT(a_score_never_rises, clock, reset, up_link.valid, down_link.best_score <= $past(up_link.best_score))
   `NPCI_ASSERT_NEXT(a_index_never_falls, clock, reset, up_link.valid, down_link.best_idx >= $past(up_link.best_idx))

endmodule

`default_nettype wire

### rtl/core/nearest_palette_color_index.sv
// Top level: nearest entry of the 256-color palette (entries 16 to 255) for an RGB pixel.
//
//   channel   ports                                  handshake
//   request   req_red, req_green, req_blue           start high while busy low
//   response  rsp_palette_index                      rsp_valid strobe, one cycle
//
// A new pixel beat is taken every cycle outside reset; results come out in request
// order. Each passes the three front stages (cube level pick, channel terms, cube
// score) and then one cell per gray entry (24).
// Busy is high only during reset; reset clears every stage's valid flag.
// The response strobe cannot be held off, so nothing in the chain ever stalls.
`default_nettype none
`include "nearest_palette_color_index_defines.svh"

module nearest_palette_color_index import npci_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire logic [CHAN_W-1:0] req_red,
   input  wire logic [CHAN_W-1:0] req_green,
   input  wire logic [CHAN_W-1:0] req_blue,
   output      logic              rsp_valid,
   output      logic [IDX_W-1:0]  rsp_palette_index
);

   logic     req_beat;
   link_type link_w [GRAY_COUNT+1];

   assign busy     = reset;
   assign req_beat = start & ~busy;

   npci_front u_front (
      .clock (clock),
      .reset (reset),
      .beat  (req_beat),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .seed  (link_w[0])
   );

   for (genvar g = 0; g < GRAY_COUNT; g++) begin : g_cell
      npci_cell #(
         .GRAY_K (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_link   (link_w[g]),
         .down_link (link_w[g+1])
      );
   end

   assign rsp_valid         = link_w[GRAY_COUNT].valid;
   assign rsp_palette_index = link_w[GRAY_COUNT].best_idx;

   `NPCI_ASSERT_IMPLY(a_rsp_index_floor, clock, reset, rsp_valid, rsp_palette_index >= IDX_W'(FIRST_ENTRY))

endmodule

`default_nettype wire
